// File: hdl/sfbr_pkg.sv
// -----------------------------------------------------------------------------
// sfbr_pkg
// Shared types and constants of the sysex firmware block receiver.
// -----------------------------------------------------------------------------
package sfbr_pkg;

   // default sizes
   localparam int FRAME_BYTES_DEF = 100;
   localparam int PAGE_BYTES_DEF  = 64;
   localparam int APP_LIMIT_DEF   = 6144;

   // framing bytes
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;

   // bytes 0..8 of a frame are kept in registers
   localparam int HDR_BYTES = 9;

   // result actions
   typedef enum logic [2:0] {
      ACT_ACK   = 3'd0,
      ACT_NAK   = 3'd1,
      ACT_ERASE = 3'd2,
      ACT_FILL  = 3'd3,
      ACT_WRITE = 3'd4,
      ACT_STORE = 3'd5,
      ACT_JUMP  = 3'd6
   } action_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_VENDOR_ONE   = 3'd0,
      REG_VENDOR_TWO   = 3'd1,
      REG_VENDOR_THREE = 3'd2,
      REG_CMD_START    = 3'd3,
      REG_CMD_RUN_APP  = 3'd4,
      REG_CMD_DATA     = 3'd5,
      REG_CMD_STORE    = 3'd6
   } reg_index_type;

   // result sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ONE,
      ST_ERASE,
      ST_FILL,
      ST_WRITE,
      ST_ACK
   } state_type;

endpackage

// File: hdl/sfbr_ram.sv
// -----------------------------------------------------------------------------
// sfbr_ram
// Simple dual-port memory, one write and one registered read per cycle.
// -----------------------------------------------------------------------------
module sfbr_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sysex_firmware_block_receiver.sv
// Results of a frame end pass through the sequencer state register, then the output register.
// Throughput: one byte per cycle while no results are pending.
// A good data block gives 3 + (PAGE_BYTES+1)/2 result words, one per cycle when rsp_tready
// stays high; req_tready is low meanwhile.
// Reset (synchronous, active high) leaves the block outside any frame with default
// registers; page memory content is undefined until decoded.
// -----------------------------------------------------------------------------
// sysex_firmware_block_receiver
// Frames sysex messages, decodes firmware pages into memory and emits flash actions.
// -----------------------------------------------------------------------------
module sysex_firmware_block_receiver
   import sfbr_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF,
   parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
   parameter int APP_LIMIT   = APP_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] midi_byte
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [2:0] action, [18:3] flash_address,
                                    // [34:19] fill_word, [50:35] fw_length,
                                    // [64:51] fw_checksum, [71:65] zero
   output logic        rsp_tlast,   // last
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_data
);

   localparam int CW        = $clog2(FRAME_BYTES + 1);
   localparam int RW        = $clog2(PAGE_BYTES + 1);
   localparam int NWORDS    = (PAGE_BYTES + 1) / 2;
   localparam int EVEN_DEP  = NWORDS;
   localparam int ODD_DEP   = PAGE_BYTES / 2;
   localparam int EAW       = $clog2(EVEN_DEP);
   localparam int OAW       = $clog2(ODD_DEP);
   localparam int WW        = $clog2(NWORDS);
   localparam logic [15:0] LIMIT = APP_LIMIT[15:0];

   // configuration registers
   logic [6:0] vend1_ff, vend2_ff, vend3_ff;
   logic [6:0] cmd_start_ff, cmd_run_ff, cmd_data_ff, cmd_store_ff;

   // frame state
   logic [CW-1:0] count_ff, count_in;
   logic          in_frame_ff, in_frame_in;
   logic [6:0]    hdr_ff [HDR_BYTES];
   logic          hdr_we;
   logic [3:0]    hdr_idx;
   logic [6:0]    xor_ff, xor_in;
   logic [6:0]    final_ff, final_in;
   // decoder state
   logic [2:0]    grp_ff, grp_in;
   logic [6:0]    bits_ff, bits_in;
   logic [RW-1:0] recvd_ff, recvd_in;
   logic          dec_done_ff, dec_done_in;
   logic          page_we;
   // sequencer
   state_type     state_ff, state_in;
   action_type    one_act_ff, one_act_in;
   logic [WW-1:0] word_ff, word_in;
   logic          go_one, go_page;
   // output register
   logic          rsp_valid_ff;
   action_type    rsp_act_ff;
   logic [15:0]   rsp_addr_ff, rsp_fill_ff, rsp_len_ff;
   logic [13:0]   rsp_sum_ff;
   logic          rsp_last_ff;
   // emission controls
   logic          slot_free, emit, emit_last, rd_en;
   action_type    emit_act;
   logic [15:0]   emit_addr, emit_fill, emit_len;
   logic [13:0]   emit_sum;
   logic [WW-1:0] rd_word;
   logic [7:0]    even_rd, odd_rd;
   logic [15:0]   page_addr;
   logic          accept;
   logic [7:0]    in_byte;

   assign accept     = req_tvalid & req_tready;
   assign in_byte    = req_tdata;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign page_addr  = {hdr_ff[7][1:0], hdr_ff[6], hdr_ff[5]};

   // configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vend1_ff     <= 7'd0;
         vend2_ff     <= 7'd19;
         vend3_ff     <= 7'd55;
         cmd_start_ff <= 7'd1;
         cmd_run_ff   <= 7'd2;
         cmd_data_ff  <= 7'd3;
         cmd_store_ff <= 7'd4;
      end else if (csr_valid) begin
         case (csr_index)
            REG_VENDOR_ONE:   vend1_ff     <= csr_data;
            REG_VENDOR_TWO:   vend2_ff     <= csr_data;
            REG_VENDOR_THREE: vend3_ff     <= csr_data;
            REG_CMD_START:    cmd_start_ff <= csr_data;
            REG_CMD_RUN_APP:  cmd_run_ff   <= csr_data;
            REG_CMD_DATA:     cmd_data_ff  <= csr_data;
            REG_CMD_STORE:    cmd_store_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // byte framing, header capture, on-the-fly page decoding and frame end decision
   always_comb begin
      logic [6:0] b0, b1, b2;
      logic       run, csum_ok, page_ok;
      count_in    = count_ff;
      in_frame_in = in_frame_ff;
      xor_in      = xor_ff;
      final_in    = final_ff;
      grp_in      = grp_ff;
      bits_in     = bits_ff;
      recvd_in    = recvd_ff;
      dec_done_in = dec_done_ff;
      hdr_we      = 1'b0;
      hdr_idx     = count_ff[3:0];
      page_we     = 1'b0;
      run         = 1'b0;
      go_one      = 1'b0;
      go_page     = 1'b0;
      one_act_in  = ACT_NAK;
      b0          = hdr_ff[0];
      b1          = hdr_ff[1];
      b2          = hdr_ff[2];
      if (accept) begin
         if (in_byte == SYSEX_START) begin
            run         = in_frame_ff;
            count_in    = '0;
            in_frame_in = 1'b1;
            xor_in      = 7'd0;
            grp_in      = 3'd0;
            recvd_in    = '0;
            dec_done_in = 1'b0;
         end else if (in_byte == SYSEX_END) begin
            run         = in_frame_ff;
            in_frame_in = 1'b0;
         end else if (in_byte[7]) begin
            in_frame_in = 1'b0;
         end else if (in_frame_ff) begin
            if (count_ff >= CW'(FRAME_BYTES)) begin
               in_frame_in = 1'b0;
            end else begin
               count_in = count_ff + 1'b1;
               final_in = in_byte[6:0];
               if (count_ff < CW'(HDR_BYTES)) begin
                  hdr_we = 1'b1;
                  if (count_ff == CW'(0)) b0 = in_byte[6:0];
                  if (count_ff == CW'(1)) b1 = in_byte[6:0];
                  if (count_ff == CW'(2)) b2 = in_byte[6:0];
               end
               if (count_ff >= CW'(3)) begin
                  xor_in = xor_ff ^ in_byte[6:0];
               end
               // vendor id check once three bytes are in
               if (count_in >= CW'(3) &&
                   (b0 != vend1_ff || b1 != vend2_ff || b2 != vend3_ff)) begin
                  in_frame_in = 1'b0;
               end
               // group decoding: high-bit byte, then seven data bytes
               if (count_ff >= CW'(HDR_BYTES) && !dec_done_ff) begin
                  grp_in = grp_ff + 3'd1;
                  if (grp_ff == 3'd0) begin
                     bits_in = in_byte[6:0];
                  end else begin
                     page_we  = 1'b1;
                     bits_in  = bits_ff >> 1;
                     recvd_in = recvd_ff + 1'b1;
                  end
                  if (16'(recvd_in) >= 16'(hdr_ff[4]) || recvd_in >= RW'(PAGE_BYTES)) begin
                     dec_done_in = 1'b1;
                  end
               end
            end
         end
      end
      // frame end decision
      csum_ok = ((xor_ff ^ final_ff) == final_ff);
      page_ok = (page_addr < LIMIT) && csum_ok && (recvd_ff == RW'(PAGE_BYTES));
      if (run && count_ff >= CW'(4)) begin
         if (hdr_ff[3] == cmd_start_ff) begin
            go_one     = 1'b1;
            one_act_in = ACT_ACK;
         end else if (hdr_ff[3] == cmd_run_ff) begin
            go_one     = 1'b1;
            one_act_in = ACT_JUMP;
         end else if (hdr_ff[3] == cmd_data_ff) begin
            go_page = page_ok;
            go_one  = !page_ok;
         end else if (hdr_ff[3] == cmd_store_ff && count_ff == CW'(9)) begin
            go_one     = 1'b1;
            one_act_in = ACT_STORE;
         end else begin
            go_one = 1'b1;
         end
      end
   end

   // frame registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         in_frame_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         in_frame_ff <= in_frame_in;
      end
   end

   always_ff @(posedge clock) begin
      xor_ff      <= xor_in;
      final_ff    <= final_in;
      grp_ff      <= grp_in;
      bits_ff     <= bits_in;
      recvd_ff    <= recvd_in;
      dec_done_ff <= dec_done_in;
      if (hdr_we) begin
         hdr_ff[hdr_idx] <= in_byte[6:0];
      end
   end

   // page memory split into even and odd bytes so one read gives a word
   sfbr_ram #(.DEPTH(EVEN_DEP), .WIDTH(8)) u_even_ram (
      .clock   (clock),
      .wr_en   (page_we && !recvd_ff[0]),
      .wr_addr (EAW'(recvd_ff >> 1)),
      .wr_data ({bits_ff[0], in_byte[6:0]}),
      .rd_en   (rd_en),
      .rd_addr (EAW'(rd_word)),
      .rd_data (even_rd)
   );

   sfbr_ram #(.DEPTH(ODD_DEP), .WIDTH(8)) u_odd_ram (
      .clock   (clock),
      .wr_en   (page_we && recvd_ff[0]),
      .wr_addr (OAW'(recvd_ff >> 1)),
      .wr_data ({bits_ff[0], in_byte[6:0]}),
      .rd_en   (rd_en),
      .rd_addr (OAW'(rd_word)),
      .rd_data (odd_rd)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go_page)     state_in = ST_ERASE;
            else if (go_one) state_in = ST_ONE;
         end
         ST_ONE:   if (slot_free) state_in = ST_IDLE;
         ST_ERASE: if (slot_free) state_in = ST_FILL;
         ST_FILL:  if (slot_free && word_ff == WW'(NWORDS - 1)) state_in = ST_WRITE;
         ST_WRITE: if (slot_free) state_in = ST_ACK;
         ST_ACK:   if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      logic [WW:0] byte_hi;
      emit      = 1'b0;
      emit_last = 1'b0;
      emit_act  = ACT_ACK;
      emit_addr = 16'd0;
      emit_fill = 16'd0;
      emit_len  = 16'd0;
      emit_sum  = 14'd0;
      rd_en     = 1'b0;
      rd_word   = '0;
      word_in   = word_ff;
      byte_hi   = {word_ff, 1'b1};
      case (state_ff)
         ST_IDLE: begin
            word_in = '0;
         end
         ST_ONE: begin
            emit      = slot_free;
            emit_last = 1'b1;
            emit_act  = one_act_ff;
            if (one_act_ff == ACT_STORE) begin
               emit_len = {hdr_ff[6][1:0], hdr_ff[5], hdr_ff[4]};
               emit_sum = {hdr_ff[8], hdr_ff[7]};
            end
         end
         ST_ERASE: begin
            emit      = slot_free;
            emit_act  = ACT_ERASE;
            emit_addr = page_addr;
            rd_en     = slot_free;
         end
         ST_FILL: begin
            emit      = slot_free;
            emit_act  = ACT_FILL;
            emit_addr = page_addr + 16'({word_ff, 1'b0});
            emit_fill = {(32'(byte_hi) < 32'(PAGE_BYTES)) ? odd_rd : 8'd0, even_rd};
            rd_en     = slot_free;
            rd_word   = word_ff + 1'b1;
            if (slot_free) word_in = word_ff + 1'b1;
         end
         ST_WRITE: begin
            emit      = slot_free;
            emit_act  = ACT_WRITE;
            emit_addr = page_addr;
         end
         ST_ACK: begin
            emit      = slot_free;
            emit_last = 1'b1;
            emit_act  = ACT_ACK;
         end
         default: ;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (state_ff == ST_IDLE) begin
         one_act_ff <= one_act_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_act_ff  <= emit_act;
         rsp_addr_ff <= emit_addr;
         rsp_fill_ff <= emit_fill;
         rsp_len_ff  <= emit_len;
         rsp_sum_ff  <= emit_sum;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_sum_ff, rsp_len_ff, rsp_fill_ff, rsp_addr_ff, rsp_act_ff};

endmodule

// File: hdl/sfbr_checker.sv
// -----------------------------------------------------------------------------
// sfbr_checker
// Port-level checks of the sysex firmware block receiver.
// -----------------------------------------------------------------------------
module sfbr_checker
   import sfbr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled word stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word withdrawn");

   // page actions never close a burst, all others always do
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == !(rsp_tdata[2:0] == ACT_ERASE ||
                                     rsp_tdata[2:0] == ACT_FILL ||
                                     rsp_tdata[2:0] == ACT_WRITE)))
      else $error("tlast does not match action");

   // no new byte is taken in the middle of a page burst
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input open during page burst");

   // an accepted erase word is followed by a fill word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata[2:0] == ACT_ERASE |=>
         rsp_tvalid && rsp_tdata[2:0] == ACT_FILL)
      else $error("erase not followed by fill");

endmodule

bind sysex_firmware_block_receiver sfbr_checker u_sfbr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/tb_sysex_firmware_block_receiver.sv
// -----------------------------------------------------------------------------
// tb_sysex_firmware_block_receiver
// Self-checking bench: sysex frames of every command kind, a full page, shared
// command codes, foreign vendors and interrupted frames are streamed in while
// a local predictor computes the expected action words.
// -----------------------------------------------------------------------------
module tb_sysex_firmware_block_receiver
   import sfbr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_MAX = FRAME_BYTES_DEF;
   localparam int PAGE_SIZE = PAGE_BYTES_DEF;
   localparam int ADDR_LIMIT = APP_LIMIT_DEF;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      action_type  act;
      logic [15:0] addr;
      logic [15:0] word;
      logic [15:0] len;
      logic [13:0] sum;
      logic        last;
   } action_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [6:0]  csr_data = '0;

   sysex_firmware_block_receiver DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [6:0]      vend [3];
   logic [6:0]      cmd_st, cmd_run, cmd_dat, cmd_sto;
   logic [7:0]      frm [FRAME_MAX];
   int              frm_cnt;
   bit              in_frm;
   logic [7:0]      pg [PAGE_SIZE];
   action_word_type expected_actions[$];

   logic [7:0]      byte_queue[$];
   int              send_idle = 15, recv_idle = 52;
   bit              hold_off = 0;
   int              errors = 0;
   int              cycles = 0;

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task automatic push_action(action_type a, logic [15:0] ad, logic [15:0] w,
                              logic [15:0] l, logic [13:0] s);
      action_word_type r;
      r = '{a, ad, w, l, s, 1'b0};
      expected_actions.push_back(r);
   endtask

   task automatic decode_page();
      logic [6:0]  x;
      logic [15:0] ad;
      logic [7:0]  hb, w0;
      int          got;
      x = '0;
      got = 0;
      hb = '0;
      for (int i = 3; i + 1 < frm_cnt; i++) x ^= frm[i][6:0];
      ad = 16'(frm[5] | (32'(frm[6]) << 7) | (32'(frm[7]) << 14));
      if (ad >= ADDR_LIMIT) begin
         push_action(ACT_NAK, 0, 0, 0, 0);
         return;
      end
      for (int c = 0; c + 9 < frm_cnt; c++) begin
         w0 = frm[9 + c];
         if ((c & 7) == 0) hb = w0;
         else begin
            if (got < PAGE_SIZE) begin
               pg[got] = w0 | {hb[0], 7'b0};
               got++;
            end
            hb = hb >> 1;
         end
         if (got >= frm[4] || got >= PAGE_SIZE) break;
      end
      if ({1'b0, x} != frm[frm_cnt - 1] || got != PAGE_SIZE) begin
         push_action(ACT_NAK, 0, 0, 0, 0);
         return;
      end
      push_action(ACT_ERASE, ad, 0, 0, 0);
      for (int i = 0; i < PAGE_SIZE; i += 2)
         push_action(ACT_FILL, ad + 16'(i), {pg[i + 1], pg[i]}, 0, 0);
      push_action(ACT_WRITE, ad, 0, 0, 0);
      push_action(ACT_ACK, 0, 0, 0, 0);
   endtask

   task automatic finish_frame();
      logic [6:0] c;
      if (frm_cnt < 4) return;
      c = frm[3][6:0];
      if (c == cmd_st) push_action(ACT_ACK, 0, 0, 0, 0);
      else if (c == cmd_run) push_action(ACT_JUMP, 0, 0, 0, 0);
      else if (c == cmd_dat) decode_page();
      else if (c == cmd_sto && frm_cnt == 9)
         push_action(ACT_STORE, 0, 0,
                     16'(frm[4] | (32'(frm[5]) << 7) | (32'(frm[6]) << 14)),
                     14'(frm[7] | (16'(frm[8]) << 7)));
      else push_action(ACT_NAK, 0, 0, 0, 0);
   endtask

   task automatic predict_byte(logic [7:0] b);
      int n0;
      n0 = expected_actions.size();
      if (b == SYSEX_START) begin
         if (in_frm) finish_frame();
         frm_cnt = 0;
         in_frm = 1;
      end else if (b == SYSEX_END) begin
         if (in_frm) finish_frame();
         in_frm = 0;
      end else if (b[7]) in_frm = 0;
      else if (in_frm) begin
         if (frm_cnt >= FRAME_MAX) in_frm = 0;
         else begin
            frm[frm_cnt] = b;
            frm_cnt++;
            if (frm_cnt >= 3 && (frm[0] != vend[0] || frm[1] != vend[1] ||
                                 frm[2] != vend[2]))
               in_frm = 0;
         end
      end
      if (expected_actions.size() > n0)
         expected_actions[$].last = 1'b1;
   endtask

   // frame builders
   task automatic header(logic [6:0] c);
      byte_queue.push_back(SYSEX_START);
      for (int i = 0; i < 3; i++) byte_queue.push_back({1'b0, vend[i]});
      byte_queue.push_back({1'b0, c});
   endtask

   task automatic page_frame(logic [15:0] ad, bit corrupt, int short_by);
      logic [7:0] body[$];
      logic [7:0] d[PAGE_SIZE];
      logic [6:0] x;
      int         total;
      x = cmd_dat;
      foreach (d[i]) d[i] = 8'($urandom);
      body.push_back(8'(PAGE_SIZE));
      body.push_back({1'b0, ad[6:0]});
      body.push_back({1'b0, ad[13:7]});
      body.push_back({6'b0, ad[15:14]});
      body.push_back(8'($urandom_range(0, 127)));
      total = PAGE_SIZE - short_by;
      for (int g = 0; g * 7 < total; g++) begin
         logic [7:0] h;
         h = '0;
         for (int k = 0; k < 7 && g * 7 + k < PAGE_SIZE; k++) h[k] = d[g * 7 + k][7];
         body.push_back(h);
         for (int k = 0; k < 7 && g * 7 + k < total; k++)
            body.push_back({1'b0, d[g * 7 + k][6:0]});
      end
      foreach (body[i]) x ^= body[i][6:0];
      header(cmd_dat);
      foreach (body[i]) byte_queue.push_back(body[i]);
      byte_queue.push_back({1'b0, corrupt ? ~x : x});
      byte_queue.push_back(SYSEX_END);
   endtask

   task automatic store_frame(int extra);
      header(cmd_sto);
      for (int i = 0; i < 5 + extra; i++) byte_queue.push_back(8'($urandom_range(0, 127)));
      byte_queue.push_back(SYSEX_END);
   endtask

   task automatic write_reg(reg_index_type idx, logic [6:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_VENDOR_ONE:   vend[0] = v;
         REG_VENDOR_TWO:   vend[1] = v;
         REG_VENDOR_THREE: vend[2] = v;
         REG_CMD_START:    cmd_st = v;
         REG_CMD_RUN_APP:  cmd_run = v;
         REG_CMD_DATA:     cmd_dat = v;
         default:          cmd_sto = v;
      endcase
   endtask

   task automatic drain();
      wait (byte_queue.size() == 0 && !req_tvalid && expected_actions.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) req_tvalid <= 1'b0;
      else if (!req_tvalid || req_tready) begin
         if (req_tvalid) predict_byte(req_tdata);
         if (byte_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
            req_tvalid <= 1'b1;
            req_tdata <= byte_queue.pop_front();
         end else req_tvalid <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      action_word_type e, g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         g = '{action_type'(rsp_tdata[2:0]), rsp_tdata[18:3], rsp_tdata[34:19],
               rsp_tdata[50:35], rsp_tdata[64:51], rsp_tlast};
         if (expected_actions.size() == 0) report($sformatf("unexpected word %h", g));
         else begin
            e = expected_actions.pop_front();
            if (g.act != e.act) report($sformatf("action %0d want %0d", g.act, e.act));
            if (g.addr != e.addr) report($sformatf("address %h want %h", g.addr, e.addr));
            if (g.word != e.word) report($sformatf("fill %h want %h", g.word, e.word));
            if (g.len != e.len) report($sformatf("length %h want %h", g.len, e.len));
            if (g.sum != e.sum) report($sformatf("checksum %h want %h", g.sum, e.sum));
            if (g.last != e.last) report($sformatf("last %b want %b", g.last, e.last));
            if (rsp_tdata[71:65] != 0) report("pad bits not zero");
         end
      end
      rsp_tready <= !reset && !hold_off && ($urandom_range(0, 99) >= recv_idle);
   end

   // long receiver stall right after reset while the sender keeps offering
   initial begin
      wait (!reset);
      hold_off = 1;
      repeat (400) @(posedge clock);
      hold_off = 0;
   end

   // timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      vend = '{7'd0, 7'd19, 7'd55};
      cmd_st = 1; cmd_run = 2; cmd_dat = 3; cmd_sto = 4;
      frm_cnt = 0;
      in_frm = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // start, jump closed by a new start, one good page, foreign vendor
      header(cmd_st); byte_queue.push_back(SYSEX_END);
      header(cmd_run); byte_queue.push_back(SYSEX_START);
      byte_queue.push_back(SYSEX_END);
      page_frame(16'($urandom_range(0, ADDR_LIMIT - PAGE_SIZE)), 0, 0);
      byte_queue.push_back(SYSEX_START); byte_queue.push_back(8'h7F);
      byte_queue.push_back(8'h7F); byte_queue.push_back(8'h7F);
      byte_queue.push_back(SYSEX_END);
      drain();

      // extreme register settings, shared command codes
      write_reg(REG_VENDOR_ONE, 7'h7F);
      write_reg(REG_VENDOR_TWO, 7'h00);
      write_reg(REG_VENDOR_THREE, 7'h7F);
      write_reg(REG_CMD_START, 7'h7F);
      write_reg(REG_CMD_RUN_APP, 7'h7F);
      write_reg(REG_CMD_DATA, 7'h00);
      write_reg(REG_CMD_STORE, 7'h00);
      send_idle = 52; recv_idle = 15;
      header(7'h7F); byte_queue.push_back(SYSEX_END);
      header(7'h00); byte_queue.push_back(SYSEX_END);
      drain();

      // random vendor, store sum and a frame broken by a status byte
      write_reg(REG_VENDOR_ONE, 7'($urandom));
      write_reg(REG_VENDOR_TWO, 7'($urandom));
      write_reg(REG_VENDOR_THREE, 7'($urandom));
      write_reg(REG_CMD_START, 7'd10);
      write_reg(REG_CMD_RUN_APP, 7'd20);
      write_reg(REG_CMD_DATA, 7'd30);
      write_reg(REG_CMD_STORE, 7'd40);
      send_idle = 0; recv_idle = 0;
      store_frame(0);
      header(cmd_st); byte_queue.push_back(8'h80); byte_queue.push_back(SYSEX_END);
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
